@@ rtl/rsoc_pkg.sv @@
// Shared types, widths and constants of the ray segment obstacle check.
// Used by the top level, the sine/cosine unit and the quotient unit.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rsoc_pkg;

  localparam int MAX_OBSTACLES_DEF = 64;

  // Sine/cosine unit.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int CORD_W       = 34;
  localparam int TRIG_W       = 20;
  localparam logic signed [CORD_W-1:0] CORDIC_START = 34'sd652032874;

  // Intersection arithmetic.
  localparam int DIFF_W = 33;
  localparam int DET_W  = 56;
  localparam int WSUM_W = 67;
  localparam int NUM_W  = 88;
  localparam int MUL_W  = 35;
  localparam int QBITS  = 41;
  localparam int QUO_W  = QBITS + 1;
  localparam int DIV_W  = 100;
  localparam int BOX_W  = 48;
  localparam logic [QBITS-1:0] QUOT_LIMIT = {1'b1, {(QBITS-1){1'b0}}};

  typedef struct packed {
    logic               action;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic [15:0]        robot_heading;
  } in_word_t;

  typedef struct packed {
    logic sees_obstacle;
    logic status;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } seg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  function automatic logic signed [CORD_W-1:0] atan_unit(input logic [STEP_W-1:0] idx);
    logic signed [CORD_W-1:0] v;
    case (idx)
      4'd0:    v = 34'sh20000000;
      4'd1:    v = 34'sh12E4051E;
      4'd2:    v = 34'sh09FB385B;
      4'd3:    v = 34'sh051111D4;
      4'd4:    v = 34'sh028B0D43;
      4'd5:    v = 34'sh0145D7E1;
      4'd6:    v = 34'sh00A2F61E;
      4'd7:    v = 34'sh00517C55;
      4'd8:    v = 34'sh0028BE53;
      4'd9:    v = 34'sh00145F2F;
      4'd10:   v = 34'sh000A2F98;
      4'd11:   v = 34'sh000517CC;
      4'd12:   v = 34'sh00028BE6;
      4'd13:   v = 34'sh000145F3;
      4'd14:   v = 34'sh0000A2FA;
      4'd15:   v = 34'sh0000517D;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rsoc_cordic.sv @@
// Iterative sine/cosine of a 16-bit binary angle, one rotation step a cycle.
// Results are signed Q4.16 (20 bits, 16 fraction bits). Depends on rsoc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsoc_cordic
  import rsoc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [15:0] heading,
  output logic             done,
  output trig_t            trig
);

  logic                     run_r, run_nxt;
  logic                     rnd_r, rnd_nxt;
  logic                     done_r, done_nxt;
  logic                     flip_r, flip_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [CORD_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  trig_t                    trig_r, trig_nxt;

  logic [31:0]              ang;
  logic                     flip_in;
  logic signed [CORD_W-1:0] dx, dy, xr, yr;

  always_comb begin
    ang     = {heading, 16'h0000};
    flip_in = ang[31] ^ ang[30];
    dx      = y_r >>> step_r;
    dy      = x_r >>> step_r;
    xr      = (x_r + CORD_W'(8192)) >>> 14;
    yr      = (y_r + CORD_W'(8192)) >>> 14;

    run_nxt  = run_r;
    rnd_nxt  = 1'b0;
    done_nxt = 1'b0;
    flip_nxt = flip_r;
    step_nxt = step_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    trig_nxt = trig_r;

    if (go) begin
      run_nxt  = 1'b1;
      flip_nxt = flip_in;
      step_nxt = '0;
      x_nxt    = CORDIC_START;
      y_nxt    = '0;
      // A half turn brings the second and third quadrants into range.
      z_nxt    = CORD_W'($signed({ang[31] ^ flip_in, ang[30:0]}));
    end else if (run_r) begin
      if (!z_r[CORD_W-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_unit(step_r);
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_unit(step_r);
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        run_nxt = 1'b0;
        rnd_nxt = 1'b1;
      end
    end else if (rnd_r) begin
      trig_nxt.cos_v = flip_r ? -xr[TRIG_W-1:0] : xr[TRIG_W-1:0];
      trig_nxt.sin_v = flip_r ? -yr[TRIG_W-1:0] : yr[TRIG_W-1:0];
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      rnd_r  <= rnd_nxt;
      done_r <= done_nxt;
    end
    flip_r <= flip_nxt;
    step_r <= step_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    trig_r <= trig_nxt;
  end

  assign done = done_r;
  assign trig = trig_r;

endmodule

`default_nettype wire

@@ rtl/rsoc_div.sv @@
// Restoring divider, one quotient bit a cycle, truncating toward zero.
// The quotient magnitude is clamped to 2^40. Depends on rsoc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsoc_div
  import rsoc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    go,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic signed [DET_W-1:0] den,
  output logic                         done,
  output logic signed [QUO_W-1:0]      quo
);

  localparam int CNT_W = $clog2(QBITS + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic             clamp_r, clamp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [QBITS-1:0] q_r, q_nxt;

  logic [NUM_W-1:0] nabs;
  logic [DET_W-1:0] dabs;
  logic [QBITS-1:0] mag;

  always_comb begin
    nabs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dabs = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);

    run_nxt   = run_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    clamp_nxt = clamp_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;

    if (go) begin
      run_nxt   = 1'b1;
      neg_nxt   = num[NUM_W-1] ^ den[DET_W-1];
      // A quotient of 2^41 or more is clamped anyway.
      clamp_nxt = DIV_W'(nabs) >= (DIV_W'(dabs) << QBITS);
      rem_nxt   = DIV_W'(nabs);
      dsh_nxt   = DIV_W'(dabs) << (QBITS - 1);
      cnt_nxt   = CNT_W'(QBITS);
      q_nxt     = '0;
    end else if (run_r) begin
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[QBITS-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QBITS-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    mag = (clamp_r || q_r > QUOT_LIMIT) ? QUOT_LIMIT : q_r;
    quo = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    neg_r   <= neg_nxt;
    clamp_r <= clamp_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    q_r     <= q_nxt;
  end

  assign done = done_r;

endmodule

`default_nettype wire

@@ rtl/ray_segment_obstacle_check.sv @@
// Obstacle segment table with a "what lies one unit ahead" query.
// Depends on rsoc_pkg, rsoc_cordic and rsoc_div.
//
// Use: a word is taken when start is high and busy is low. An add word
// (action 0) stores one segment in the next free table entry, or reports
// status 1 when the table is full. A query word (action 1) forms the unit
// segment ahead of the robot and tests it against the stored segments.
// Every word gives exactly one result word, shown on out_word for one
// cycle with out_valid high; the receiver cannot stall it.
// An add, and a query on an empty table, answer from the idle state with a
// registered result word. A query runs the sine/cosine unit, then walks the
// stored segments: table read, eight steps through one shared multiplier,
// 41 steps of the two quotient units, box test; a parallel segment leaves
// after the determinant step. A hit ends the walk early. busy stays high
// for the whole query. Reset empties the table (the entries keep stale data
// that is never read) and sets match_margin to 1. The user must write
// match_margin via cfg_we only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module ray_segment_obstacle_check
  import rsoc_pkg::*;
#(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  output out_word_t        out_word,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_FETCH, S_LOAD, S_DET0, S_DET1, S_W0, S_W1,
    S_NX0, S_NX1, S_NY0, S_NY1, S_DSTART, S_DIV, S_BOX
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [15:0]              margin_r, margin_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;
  logic signed [31:0]       rx_r, rx_nxt, ry_r, ry_nxt;
  logic signed [TRIG_W-1:0] s_r, s_nxt, c_r, c_nxt;
  logic signed [DIFF_W-1:0] a2_r, a2_nxt, b2_r, b2_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [DET_W-1:0]  det_r, det_nxt;
  logic signed [WSUM_W-1:0] w_r, w_nxt;
  logic signed [NUM_W-1:0]  nx_r, nx_nxt, ny_r, ny_nxt;

  // Segment table.
  seg_t             mem [MAX_OBSTACLES];
  seg_t             rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  seg_t             mem_wdata;

  logic  cord_go, cord_done;
  trig_t trig;
  logic  div_go, divx_done, divy_done;
  logic signed [QUO_W-1:0] qx, qy;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;

  logic                    accept, full, last_seg, hit;
  logic signed [BOX_W-1:0] m, ix, iy, rxw, ryw, fxw, fyw, sxw, syw, exw, eyw;

  function automatic logic in_box(input logic signed [BOX_W-1:0] p,
                                  input logic signed [BOX_W-1:0] u,
                                  input logic signed [BOX_W-1:0] v,
                                  input logic signed [BOX_W-1:0] mm);
    logic signed [BOX_W-1:0] lo, hi;
    lo = (u < v) ? u : v;
    hi = (u < v) ? v : u;
    return (lo <= p + mm) && (p - mm <= hi);
  endfunction

  rsoc_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (cord_go),
    .heading (in_word.robot_heading),
    .done    (cord_done),
    .trig    (trig)
  );

  rsoc_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (nx_r),
    .den   (det_r),
    .done  (divx_done),
    .quo   (qx)
  );

  rsoc_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (ny_r),
    .den   (det_r),
    .done  (divy_done),
    .quo   (qy)
  );

  // One shared multiplier; the state picks its operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DET0: begin mul_a = MUL_W'(c_r);  mul_b = MUL_W'(b2_r); end
      S_DET1: begin mul_a = MUL_W'(s_r);  mul_b = MUL_W'(a2_r); end
      S_W0:   begin mul_a = MUL_W'(a2_r); mul_b = MUL_W'(dx_r); end
      S_W1:   begin mul_a = MUL_W'(b2_r); mul_b = MUL_W'(dy_r); end
      S_NX0:  begin mul_a = MUL_W'(s_r);  mul_b = $signed({1'b0, w_r[33:0]}); end
      S_NX1:  begin mul_a = MUL_W'(s_r);  mul_b = MUL_W'($signed(w_r[WSUM_W-1:34])); end
      S_NY0:  begin mul_a = MUL_W'(c_r);  mul_b = $signed({1'b0, w_r[33:0]}); end
      S_NY1:  begin mul_a = MUL_W'(c_r);  mul_b = MUL_W'($signed(w_r[WSUM_W-1:34])); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    m   = BOX_W'(margin_r);
    rxw = BOX_W'(rx_r);
    ryw = BOX_W'(ry_r);
    fxw = rxw + BOX_W'(s_r);
    fyw = ryw + BOX_W'(c_r);
    sxw = BOX_W'(rdata_r.sx);
    syw = BOX_W'(rdata_r.sy);
    exw = BOX_W'(rdata_r.ex);
    eyw = BOX_W'(rdata_r.ey);
    ix  = rxw + BOX_W'(qx);
    iy  = ryw + BOX_W'(qy);
    hit = in_box(ix, rxw, fxw, m) && in_box(iy, ryw, fyw, m) &&
          in_box(ix, sxw, exw, m) && in_box(iy, syw, eyw, m);
  end

  always_comb begin
    accept    = start && (state_r == S_IDLE);
    full      = (count_r == CNT_W'(MAX_OBSTACLES));
    last_seg  = (CNT_W'(idx_r) + 1'b1 == count_r);

    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    margin_nxt    = cfg_we ? cfg_wdata : margin_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    rx_nxt = rx_r;  ry_nxt = ry_r;
    s_nxt  = s_r;   c_nxt  = c_r;
    a2_nxt = a2_r;  b2_nxt = b2_r;  dx_nxt = dx_r;  dy_nxt = dy_r;
    det_nxt = det_r;
    w_nxt   = w_r;
    nx_nxt  = nx_r;
    ny_nxt  = ny_r;
    cord_go   = 1'b0;
    div_go    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = count_r[IDX_W-1:0];
    mem_wdata = '{sx: in_word.seg_start_x, sy: in_word.seg_start_y,
                  ex: in_word.seg_end_x,   ey: in_word.seg_end_y};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.action == ACT_ADD) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{sees_obstacle: 1'b0, status: full};
            if (!full) begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{sees_obstacle: 1'b0, status: 1'b0};
          end else begin
            rx_nxt    = in_word.robot_x;
            ry_nxt    = in_word.robot_y;
            cord_go   = 1'b1;
            state_nxt = S_TRIG;
          end
        end
      end
      S_TRIG: begin
        if (cord_done) begin
          s_nxt     = trig.sin_v;
          c_nxt     = trig.cos_v;
          idx_nxt   = '0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_LOAD;
      S_LOAD: begin
        a2_nxt    = DIFF_W'(rdata_r.ey) - DIFF_W'(rdata_r.sy);
        b2_nxt    = DIFF_W'(rdata_r.sx) - DIFF_W'(rdata_r.ex);
        dx_nxt    = DIFF_W'(rdata_r.sx) - DIFF_W'(rx_r);
        dy_nxt    = DIFF_W'(rdata_r.sy) - DIFF_W'(ry_r);
        state_nxt = S_DET0;
      end
      S_DET0: begin
        det_nxt   = prod[DET_W-1:0];
        state_nxt = S_DET1;
      end
      S_DET1: begin
        det_nxt   = det_r + prod[DET_W-1:0];
        state_nxt = S_W0;
      end
      S_W0: begin
        // A parallel or zero-length segment has no intersection.
        if (det_r == '0) begin
          if (last_seg) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{sees_obstacle: 1'b0, status: 1'b0};
            state_nxt     = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_FETCH;
          end
        end else begin
          w_nxt     = prod[WSUM_W-1:0];
          state_nxt = S_W1;
        end
      end
      S_W1: begin
        w_nxt     = w_r + prod[WSUM_W-1:0];
        state_nxt = S_NX0;
      end
      S_NX0: begin
        nx_nxt    = NUM_W'(prod);
        state_nxt = S_NX1;
      end
      S_NX1: begin
        nx_nxt    = nx_r + $signed({prod[NUM_W-35:0], 34'd0});
        state_nxt = S_NY0;
      end
      S_NY0: begin
        ny_nxt    = NUM_W'(prod);
        state_nxt = S_NY1;
      end
      S_NY1: begin
        ny_nxt    = ny_r + $signed({prod[NUM_W-35:0], 34'd0});
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_go    = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (divx_done) state_nxt = S_BOX;
      end
      S_BOX: begin
        if (hit || last_seg) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{sees_obstacle: hit, status: 1'b0};
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      margin_r    <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      margin_r    <= margin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
    idx_r  <= idx_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    s_r    <= s_nxt;
    c_r    <= c_nxt;
    a2_r   <= a2_nxt;
    b2_r   <= b2_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    det_r  <= det_nxt;
    w_r    <= w_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A result word always leaves the block ready for the next word.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result word while a query is still running");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_OBSTACLES))
    else $error("obstacle count beyond table depth");

  a_trig_state: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> state_r == S_TRIG)
    else $error("sine/cosine result outside its wait state");

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    divx_done |-> divy_done && state_r == S_DIV)
    else $error("quotient units out of step");

endmodule

`default_nettype wire
